>>> rtl/ffac_pkg.sv
// Package for the first-fit pool allocator: request/response structs,
// status and register codes, and the sequencer state type.
// No dependencies.
`timescale 1ns / 1ps

package ffac_pkg;

  localparam int ADDR_W    = 32;
  localparam int LEN_W     = 17;
  localparam int UCNT_W    = 9;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_A_SCAN,
    S_S_SCAN,
    S_A_CARVE,
    S_F_SCAN,
    S_F_CLR,
    S_I_SCAN,
    S_I_DEC,
    S_SHIFT,
    S_I_PUT,
    S_DONE
  } state_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_SPACE  = 3'd1,
    ST_NO_SLOT   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_BAD_LEN   = 3'd4
  } status_e;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POOL_BASE = 1'b0,
    CFG_POOL_SIZE = 1'b1
  } cfg_e;

  typedef struct packed {
    logic              req_type;
    logic [LEN_W-1:0]  alloc_len;
    logic [ADDR_W-1:0] free_addr;
  } req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [ADDR_W-1:0] addr;
    logic [UCNT_W-1:0] use_count;
  } rsp_t;

endpackage

>>> rtl/first_fit_allocator_coalescing.sv
// First-fit byte pool allocator with a coalescing, address-sorted free list.
// Holds the free-list and record memories and the sequencer; uses ffac_pkg.
// Depends on: ffac_pkg.
//
// Channel | Direction | Handshake              | Payload
// --------+-----------+------------------------+------------------------------
// request | in        | start && !busy         | req_i (req_type, len, addr)
// result  | out       | rsp_valid_o, one cycle | rsp_o (status, addr, count)
// config  | in        | cfg_valid_i, cfg_ready | cfg_idx_i, cfg_data_i
//
// A request is sequenced through scans of the free list (up to the free count),
// scans of the record slots (up to MAX_RECORDS) and shifts that move free-list
// entries, all through the single read port of each memory. After reset and
// after each pool_size transfer a clearing pass over all MAX_RECORDS record
// slots runs with busy high.
// The result strobe cannot be stalled; busy stays high until it has been shown.
`timescale 1ns / 1ps

module first_fit_allocator_coalescing
  import ffac_pkg::*;
#(
  parameter int MAX_RECORDS = 256,
  parameter int POOL_BYTES  = 65536
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  req_t                 req_i,
  output logic                 rsp_valid_o,
  output rsp_t                 rsp_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ADDR_W-1:0]    cfg_data_i
);

  localparam int OW  = $clog2(POOL_BYTES);
  localparam int LW  = OW + 1;
  localparam int XW  = (LW > LEN_W) ? LW : LEN_W;
  localparam int FD  = MAX_RECORDS + 1;
  localparam int FAW = $clog2(FD);
  localparam int NW  = $clog2(FD + 1);
  localparam int RAW = $clog2(MAX_RECORDS);
  localparam int RCW = $clog2(MAX_RECORDS + 1);
  localparam int FWW = OW + LW;
  localparam int RWW = 1 + OW + LW;

  state_e            state_q, state_d;
  logic [ADDR_W-1:0] base_q, base_d;
  logic [LEN_W-1:0]  size_q, size_d;
  req_t              req_q, req_d;
  status_e           status_q, status_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [RCW-1:0]    live_q, live_d;
  logic [NW-1:0]     fcnt_q, fcnt_d;
  logic [NW-1:0]     cnt_q, cnt_d;
  logic              rv_q, rv_d;
  logic [NW-1:0]     idx_q, idx_d;
  logic [OW-1:0]     cur_s_q, cur_s_d;
  logic [LW-1:0]     cur_l_q, cur_l_d;
  logic [RAW-1:0]    slot_q, slot_d;
  logic [OW-1:0]     prv_s_q, prv_s_d;
  logic [LW-1:0]     prv_l_q, prv_l_d;
  logic [OW-1:0]     nxt_s_q, nxt_s_d;
  logic [LW-1:0]     nxt_l_q, nxt_l_d;
  logic [NW-1:0]     p_q, p_d;
  logic [NW-1:0]     rem_q, rem_d;
  logic              up_q, up_d;
  logic              ins_q, ins_d;
  logic              pend_q, pend_d;
  logic [NW-1:0]     wa_q, wa_d;

  logic [FWW-1:0] fl_mem [FD];
  logic [RWW-1:0] rec_mem [MAX_RECORDS];
  logic [FWW-1:0] fl_rd_q;
  logic [RWW-1:0] rec_rd_q;
  logic           fl_we, rec_we;
  logic [FAW-1:0] fl_wa;
  logic [RAW-1:0] rec_wa;
  logic [FWW-1:0] fl_wd;
  logic [RWW-1:0] rec_wd;

  logic [OW-1:0]     fr_s, rr_s;
  logic [LW-1:0]     fr_l, rr_l;
  logic              rr_used;
  logic [XW-1:0]     size_x, len_x;
  logic [LW-1:0]     eff_l, len_l;
  logic [ADDR_W-1:0] off32;
  logic [NW-1:0]     lim, pm1;
  logic              issue, hit, scan_end, prev_ok, next_ok;
  logic              cfg_wr, size_wr;

  assign fr_s    = fl_rd_q[FWW-1:LW];
  assign fr_l    = fl_rd_q[LW-1:0];
  assign rr_used = rec_rd_q[RWW-1];
  assign rr_s    = rec_rd_q[OW+LW-1:LW];
  assign rr_l    = rec_rd_q[LW-1:0];

  assign size_x = XW'(size_q);
  assign eff_l  = (size_x > XW'(POOL_BYTES)) ? LW'(POOL_BYTES) : LW'(size_x);
  assign len_x  = XW'(req_q.alloc_len);
  assign len_l  = LW'(req_q.alloc_len);
  assign off32  = req_q.free_addr - base_q;
  assign pm1    = p_q - NW'(1);

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign size_wr     = cfg_wr && (cfg_idx_i == CFG_POOL_SIZE);

  assign lim   = (state_q == S_S_SCAN || state_q == S_F_SCAN) ? NW'(MAX_RECORDS) : fcnt_q;
  assign issue = cnt_q < lim;
  assign scan_end = !rv_q && !issue;

  always_comb begin
    case (state_q)
      S_A_SCAN: hit = rv_q && (XW'(fr_l) >= len_x);
      S_S_SCAN: hit = rv_q && !rr_used;
      S_F_SCAN: hit = rv_q && rr_used && (ADDR_W'(rr_s) == off32);
      S_I_SCAN: hit = rv_q && (fr_s >= cur_s_q);
      default:  hit = 1'b0;
    endcase
  end

  assign prev_ok = (p_q != '0) &&
                   ((LW+1)'(prv_s_q) + (LW+1)'(prv_l_q) == (LW+1)'(cur_s_q));
  assign next_ok = (p_q < fcnt_q) &&
                   ((LW+1)'(cur_s_q) + (LW+1)'(cur_l_q) == (LW+1)'(nxt_s_q));

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_INIT: begin
        if (cnt_q == NW'(MAX_RECORDS - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          if (req_i.req_type == REQ_FREE) state_d = S_F_SCAN;
          else if (req_i.alloc_len == '0) state_d = S_DONE;
          else state_d = S_A_SCAN;
        end
      end
      S_A_SCAN: begin
        if (hit) state_d = S_S_SCAN;
        else if (scan_end) state_d = S_DONE;
      end
      S_S_SCAN: begin
        if (hit) state_d = S_A_CARVE;
        else if (scan_end) state_d = S_DONE;
      end
      S_A_CARVE: begin
        state_d = (cur_l_q == len_l) ? S_SHIFT : S_DONE;
      end
      S_F_SCAN: begin
        if (hit) state_d = S_F_CLR;
        else if (scan_end) state_d = S_DONE;
      end
      S_F_CLR: state_d = S_I_SCAN;
      S_I_SCAN: begin
        if (hit || scan_end) state_d = S_I_DEC;
      end
      S_I_DEC: begin
        state_d = (prev_ok == next_ok) ? S_SHIFT : S_DONE;
      end
      S_SHIFT: begin
        if (rem_q == '0 && !pend_q) state_d = ins_q ? S_I_PUT : S_DONE;
      end
      S_I_PUT: state_d = S_DONE;
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
    if (size_wr) state_d = S_INIT;
  end

  always_comb begin
    base_d   = base_q;
    size_d   = size_q;
    req_d    = req_q;
    status_d = status_q;
    addr_d   = addr_q;
    live_d   = live_q;
    fcnt_d   = fcnt_q;
    cnt_d    = cnt_q;
    rv_d     = rv_q;
    idx_d    = idx_q;
    cur_s_d  = cur_s_q;
    cur_l_d  = cur_l_q;
    slot_d   = slot_q;
    prv_s_d  = prv_s_q;
    prv_l_d  = prv_l_q;
    nxt_s_d  = nxt_s_q;
    nxt_l_d  = nxt_l_q;
    p_d      = p_q;
    rem_d    = rem_q;
    up_d     = up_q;
    ins_d    = ins_q;
    pend_d   = pend_q;
    wa_d     = wa_q;
    fl_we    = 1'b0;
    fl_wa    = p_q[FAW-1:0];
    fl_wd    = {cur_s_q, cur_l_q};
    rec_we   = 1'b0;
    rec_wa   = slot_q;
    rec_wd   = '0;

    case (state_q)
      S_INIT: begin
        rec_we = 1'b1;
        rec_wa = cnt_q[RAW-1:0];
        if (cnt_q == '0) begin
          fl_we  = (eff_l != '0);
          fl_wa  = '0;
          fl_wd  = {{OW{1'b0}}, eff_l};
          fcnt_d = (eff_l != '0) ? NW'(1) : '0;
          live_d = '0;
        end
        cnt_d = cnt_q + NW'(1);
      end
      S_IDLE: begin
        if (start) begin
          req_d    = req_i;
          status_d = ST_OK;
          addr_d   = '0;
          cnt_d    = '0;
          rv_d     = 1'b0;
          if (req_i.req_type == REQ_ALLOC && req_i.alloc_len == '0) status_d = ST_BAD_LEN;
        end
      end
      S_A_SCAN, S_S_SCAN, S_F_SCAN, S_I_SCAN: begin
        if (hit) begin
          rv_d  = 1'b0;
          cnt_d = '0;
        end else begin
          rv_d  = issue;
          idx_d = cnt_q;
          if (issue) cnt_d = cnt_q + NW'(1);
        end
        case (state_q)
          S_A_SCAN: begin
            if (hit) begin
              cur_s_d = fr_s;
              cur_l_d = fr_l;
              p_d     = idx_q;
            end else if (scan_end) begin
              status_d = ST_NO_SPACE;
            end
          end
          S_S_SCAN: begin
            if (hit) slot_d = idx_q[RAW-1:0];
            else if (scan_end) status_d = ST_NO_SLOT;
          end
          S_F_SCAN: begin
            if (hit) begin
              slot_d  = idx_q[RAW-1:0];
              cur_s_d = rr_s;
              cur_l_d = rr_l;
            end else if (scan_end) begin
              status_d = ST_NOT_FOUND;
            end
          end
          default: begin
            if (hit) begin
              p_d     = idx_q;
              nxt_s_d = fr_s;
              nxt_l_d = fr_l;
            end else if (rv_q) begin
              prv_s_d = fr_s;
              prv_l_d = fr_l;
            end else if (scan_end) begin
              p_d = fcnt_q;
            end
          end
        endcase
      end
      S_A_CARVE: begin
        rec_we = 1'b1;
        rec_wd = {1'b1, cur_s_q, len_l};
        live_d = live_q + RCW'(1);
        addr_d = base_q + ADDR_W'(cur_s_q);
        if (cur_l_q == len_l) begin
          cnt_d  = p_q + NW'(1);
          rem_d  = fcnt_q - NW'(1) - p_q;
          up_d   = 1'b0;
          ins_d  = 1'b0;
          pend_d = 1'b0;
        end else begin
          fl_we = 1'b1;
          fl_wd = {OW'(LW'(cur_s_q) + len_l), LW'(cur_l_q - len_l)};
        end
      end
      S_F_CLR: begin
        rec_we = 1'b1;
        if (live_q != '0) live_d = live_q - RCW'(1);
        cnt_d = '0;
        rv_d  = 1'b0;
      end
      S_I_DEC: begin
        if (prev_ok && next_ok) begin
          fl_we  = 1'b1;
          fl_wa  = pm1[FAW-1:0];
          fl_wd  = {prv_s_q, LW'(prv_l_q + cur_l_q + nxt_l_q)};
          cnt_d  = p_q + NW'(1);
          rem_d  = fcnt_q - NW'(1) - p_q;
          up_d   = 1'b0;
          ins_d  = 1'b0;
          pend_d = 1'b0;
        end else if (prev_ok) begin
          fl_we = 1'b1;
          fl_wa = pm1[FAW-1:0];
          fl_wd = {prv_s_q, LW'(prv_l_q + cur_l_q)};
        end else if (next_ok) begin
          fl_we = 1'b1;
          fl_wd = {cur_s_q, LW'(nxt_l_q + cur_l_q)};
        end else begin
          cnt_d  = fcnt_q - NW'(1);
          rem_d  = fcnt_q - p_q;
          up_d   = 1'b1;
          ins_d  = 1'b1;
          pend_d = 1'b0;
        end
      end
      S_SHIFT: begin
        if (pend_q) begin
          fl_we = 1'b1;
          fl_wa = wa_q[FAW-1:0];
          fl_wd = fl_rd_q;
        end
        if (rem_q != '0) begin
          pend_d = 1'b1;
          wa_d   = up_q ? cnt_q + NW'(1) : cnt_q - NW'(1);
          cnt_d  = up_q ? cnt_q - NW'(1) : cnt_q + NW'(1);
          rem_d  = rem_q - NW'(1);
        end else begin
          pend_d = 1'b0;
          if (!pend_q && !ins_q) fcnt_d = fcnt_q - NW'(1);
        end
      end
      S_I_PUT: begin
        fl_we  = 1'b1;
        fcnt_d = fcnt_q + NW'(1);
      end
      default: begin
      end
    endcase

    if (cfg_wr) begin
      if (cfg_idx_i == CFG_POOL_BASE) begin
        base_d = cfg_data_i;
      end else begin
        size_d = cfg_data_i[LEN_W-1:0];
        cnt_d  = '0;
      end
    end
  end

  always_comb begin
    busy              = (state_q != S_IDLE);
    rsp_valid_o       = (state_q == S_DONE);
    rsp_o.status      = status_q;
    rsp_o.addr        = addr_q;
    rsp_o.use_count   = UCNT_W'(live_q);
  end

  always_ff @(posedge clk_i) begin
    if (fl_we) fl_mem[fl_wa] <= fl_wd;
    fl_rd_q <= fl_mem[cnt_q[FAW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (rec_we) rec_mem[rec_wa] <= rec_wd;
    rec_rd_q <= rec_mem[cnt_q[RAW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      base_q  <= '0;
      size_q  <= LEN_W'(65536);
      live_q  <= '0;
      fcnt_q  <= '0;
      cnt_q   <= '0;
      rv_q    <= 1'b0;
      pend_q  <= 1'b0;
      rem_q   <= '0;
      up_q    <= 1'b0;
      ins_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      base_q  <= base_d;
      size_q  <= size_d;
      live_q  <= live_d;
      fcnt_q  <= fcnt_d;
      cnt_q   <= cnt_d;
      rv_q    <= rv_d;
      pend_q  <= pend_d;
      rem_q   <= rem_d;
      up_q    <= up_d;
      ins_q   <= ins_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    status_q <= status_d;
    addr_q   <= addr_d;
    idx_q    <= idx_d;
    cur_s_q  <= cur_s_d;
    cur_l_q  <= cur_l_d;
    slot_q   <= slot_d;
    prv_s_q  <= prv_s_d;
    prv_l_q  <= prv_l_d;
    nxt_s_q  <= nxt_s_d;
    nxt_l_q  <= nxt_l_d;
    p_q      <= p_d;
    wa_q     <= wa_d;
  end

  a_live_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    live_q <= RCW'(MAX_RECORDS))
    else $error("live count exceeds record capacity");

  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fcnt_q <= NW'(FD))
    else $error("free list count exceeds its depth");

  a_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted request did not raise busy");

  a_rsp_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !size_wr |=> !busy && !rsp_valid_o)
    else $error("result strobe not followed by idle");

endmodule
